/* rtl/nearest_point_search_defines.svh */
// assertion macros for the nearest point search block
`ifndef NEAREST_POINT_SEARCH_DEFINES_SVH
`define NEAREST_POINT_SEARCH_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent holds, consequent holds in the same cycle
`define NPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nearest point search check failed");
// antecedent holds, consequent holds in the next cycle
`define NPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nearest point search check failed");
`else
`define NPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define NPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/nps_pkg.sv */
// shared types and constants of the nearest point search block
`timescale 1ns / 1ps

package nps_pkg;

    localparam int REQ_W   = 2;
    localparam int COORD_W = 12;
    localparam int DIST_W  = 25;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR = 2'd0,
        REQ_LOAD  = 2'd1,
        REQ_QUERY = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // control that travels along the distance chain with each sample
    typedef struct packed {
        logic valid;
        logic first;
    } ctl_t;

endpackage

/* rtl/nps_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps

module nps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                                           clk,
    input  logic                                           we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  logic [WIDTH-1:0]                               wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic [WIDTH-1:0]                               rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/nps_axis_cell.sv */
// one axis cell: absolute difference, then square, one register each
`timescale 1ns / 1ps

module nps_axis_cell #(
    parameter int COORD_BITS = 12
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  nps_pkg::ctl_t             ctl_i,
    input  logic [COORD_BITS-1:0]     p_i,
    input  logic [COORD_BITS-1:0]     q_i,
    output nps_pkg::ctl_t             ctl_o,
    output logic [COORD_BITS-1:0]     p_o,
    output logic [2*COORD_BITS-1:0]   sq_o,
    output logic                      busy
);

    nps_pkg::ctl_t              ctl_a_reg;
    nps_pkg::ctl_t              ctl_b_reg;
    logic [COORD_BITS-1:0]      diff_reg;
    logic [COORD_BITS-1:0]      diff_next;
    logic [COORD_BITS-1:0]      p_a_reg;
    logic [COORD_BITS-1:0]      p_b_reg;
    logic [2*COORD_BITS-1:0]    sq_reg;

    assign diff_next = (p_i > q_i) ? (p_i - q_i) : (q_i - p_i);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end
        else
        begin
            ctl_a_reg <= ctl_i;
            ctl_b_reg <= ctl_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        p_a_reg  <= p_i;
        sq_reg   <= diff_reg * diff_reg;
        p_b_reg  <= p_a_reg;
    end

    assign ctl_o = ctl_b_reg;
    assign p_o   = p_b_reg;
    assign sq_o  = sq_reg;
    assign busy  = ctl_a_reg.valid | ctl_b_reg.valid;

endmodule

/* rtl/nps_best.sv */
// running minimum of the distance chain, first sample wins on a tie
`timescale 1ns / 1ps

module nps_best #(
    parameter int COORD_BITS = 12
) (
    input  logic                      clk,
    input  nps_pkg::ctl_t             ctl_i,
    input  logic [2*COORD_BITS:0]     dist_i,
    input  logic [COORD_BITS-1:0]     px_i,
    input  logic [COORD_BITS-1:0]     py_i,
    output logic [2*COORD_BITS:0]     best_d,
    output logic [COORD_BITS-1:0]     best_x,
    output logic [COORD_BITS-1:0]     best_y
);

    logic [2*COORD_BITS:0]  best_d_reg;
    logic [COORD_BITS-1:0]  best_x_reg;
    logic [COORD_BITS-1:0]  best_y_reg;
    logic                   take;

    assign take = ctl_i.valid & (ctl_i.first | (dist_i < best_d_reg));

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_d_reg <= dist_i;
            best_x_reg <= px_i;
            best_y_reg <= py_i;
        end
    end

    assign best_d = best_d_reg;
    assign best_x = best_x_reg;
    assign best_y = best_y_reg;

endmodule

/* rtl/nearest_point_search.sv */
// top level of the nearest point search block
`timescale 1ns / 1ps
`include "nearest_point_search_defines.svh"

// nearest point search over a stored set of 2-D reference points
// input channel (in_valid / in_stall): one beat carries req_type, x and y
//   clear empties the set and the overflow flag, load appends a point,
//   query asks for the stored point nearest to (x, y), code 3 is dropped
// output channel (out_valid / out_stall): one beat per query with the
//   nearest point, its squared distance and the empty / overflow flags
// clear and load are taken back to back, with no stall between them
// a query against N stored points reads them one after another from the
//   point memory, passes each through difference, square, sum and compare,
//   then waits for the chain to drain before the output register is loaded
// the single read port of the point memory sets the length of the scan
// against an empty set the query skips the scan and goes straight to finish
// in_stall stays high until the result is in the output register, so the
//   block takes no new beat while a query is still in flight
// a waiting result holds in the output register while out_stall is high and
//   the block takes the next beats; a following query holds its result until
//   that register frees
// reset clears the point count and overflow flag, the memory is not cleared
//   since only entries written since the last clear are read, ties go to the
//   point loaded first
module nearest_point_search #(
    parameter int MAX_POINTS = 4096,
    parameter int COORD_BITS = 12
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [nps_pkg::REQ_W-1:0]        req_type,
    input  logic [nps_pkg::COORD_W-1:0]      x,
    input  logic [nps_pkg::COORD_W-1:0]      y,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [nps_pkg::COORD_W-1:0]      nearest_x,
    output logic [nps_pkg::COORD_W-1:0]      nearest_y,
    output logic [nps_pkg::DIST_W-1:0]       sq_distance,
    output logic                             set_empty,
    output logic                             overflowed
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int PW = 2 * COORD_BITS;
    localparam int DW = 2 * COORD_BITS + 1;

    // control state
    nps_pkg::state_t            state_reg;
    nps_pkg::state_t            state_next;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;
    logic                       ovf_reg;
    logic                       ovf_next;
    logic [AW-1:0]              scan_addr_reg;
    logic [AW-1:0]              scan_addr_next;
    logic                       rdv_reg;
    logic                       rd_first_reg;
    nps_pkg::ctl_t              sum_ctl_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;

    // query payload
    logic [COORD_BITS-1:0]      qx_reg;
    logic [COORD_BITS-1:0]      qy_reg;
    logic                       empty_reg;

    // output payload
    logic [nps_pkg::COORD_W-1:0] out_x_reg;
    logic [nps_pkg::COORD_W-1:0] out_y_reg;
    logic [nps_pkg::DIST_W-1:0]  out_d_reg;
    logic                        out_empty_reg;
    logic                        out_ovf_reg;

    // datapath
    logic [COORD_BITS-1:0]      in_x;
    logic [COORD_BITS-1:0]      in_y;
    logic                       in_acc;
    logic                       is_load;
    logic                       is_clear;
    logic                       is_query;
    logic                       store_full;
    logic                       ram_we;
    logic [PW-1:0]              ram_rdata;
    logic                       scan_last;
    logic                       scan_or_drain;
    logic                       chain_busy;
    logic                       out_free;
    logic                       fin_load;
    nps_pkg::ctl_t              rd_ctl;
    nps_pkg::ctl_t              cell_ctl;
    nps_pkg::ctl_t              cell_ctl_y;
    logic [COORD_BITS-1:0]      cell_px;
    logic [COORD_BITS-1:0]      cell_py;
    logic [PW-1:0]              sq_x;
    logic [PW-1:0]              sq_y;
    logic                       busy_x;
    logic                       busy_y;
    logic [DW-1:0]              sum_reg;
    logic [COORD_BITS-1:0]      sum_px_reg;
    logic [COORD_BITS-1:0]      sum_py_reg;
    logic [DW-1:0]              best_d;
    logic [COORD_BITS-1:0]      best_x;
    logic [COORD_BITS-1:0]      best_y;

    // coordinates are taken modulo the coordinate range
    assign in_x = COORD_BITS'(x);
    assign in_y = COORD_BITS'(y);

    assign in_stall = (state_reg != nps_pkg::ST_IDLE);
    assign in_acc   = in_valid & ~in_stall;

    always_comb
    begin
        is_clear = 1'b0;
        is_load  = 1'b0;
        is_query = 1'b0;
        case (nps_pkg::req_t'(req_type))
            nps_pkg::REQ_CLEAR: is_clear = in_acc;
            nps_pkg::REQ_LOAD:  is_load  = in_acc;
            nps_pkg::REQ_QUERY: is_query = in_acc;
            default:            ;
        endcase
    end

    assign store_full    = (count_reg == CW'(MAX_POINTS));
    assign ram_we        = is_load & ~store_full;
    assign scan_last     = (CW'(scan_addr_reg) == (count_reg - CW'(1)));
    assign scan_or_drain = (state_reg == nps_pkg::ST_SCAN) || (state_reg == nps_pkg::ST_DRAIN);
    assign chain_busy    = rdv_reg | busy_x | busy_y | sum_ctl_reg.valid;
    assign out_free      = ~out_valid_reg | ~out_stall;
    assign fin_load      = (state_reg == nps_pkg::ST_FINISH) & out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nps_pkg::ST_IDLE:
            begin
                if (is_query)
                begin
                    state_next = (count_reg == '0) ? nps_pkg::ST_FINISH : nps_pkg::ST_SCAN;
                end
            end
            nps_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = nps_pkg::ST_DRAIN;
                end
            end
            nps_pkg::ST_DRAIN:
            begin
                if (!chain_busy)
                begin
                    state_next = nps_pkg::ST_FINISH;
                end
            end
            nps_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = nps_pkg::ST_IDLE;
                end
            end
            default: state_next = nps_pkg::ST_IDLE;
        endcase
    end

    // counters and flags
    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        scan_addr_next = '0;
        if (is_clear)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else if (is_load)
        begin
            if (store_full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
        if (state_reg == nps_pkg::ST_SCAN)
        begin
            scan_addr_next = scan_addr_reg + AW'(1);
        end
        out_valid_next = fin_load | (out_valid_reg & out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nps_pkg::ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            scan_addr_reg <= '0;
            rdv_reg       <= 1'b0;
            rd_first_reg  <= 1'b0;
            sum_ctl_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            scan_addr_reg <= scan_addr_next;
            rdv_reg       <= (state_reg == nps_pkg::ST_SCAN);
            rd_first_reg  <= (state_reg == nps_pkg::ST_SCAN) & (scan_addr_reg == '0);
            sum_ctl_reg   <= cell_ctl;
            out_valid_reg <= out_valid_next;
        end
    end

    // query point, held for the whole scan
    always_ff @(posedge clk)
    begin
        if (is_query)
        begin
            qx_reg    <= in_x;
            qy_reg    <= in_y;
            empty_reg <= (count_reg == '0);
        end
    end

    // point memory: y above x
    nps_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata ({in_y, in_x}),
        .raddr (scan_addr_reg),
        .rdata (ram_rdata)
    );

    assign rd_ctl.valid = rdv_reg;
    assign rd_ctl.first = rd_first_reg;

    // one cell per axis, running side by side
    nps_axis_cell #(
        .COORD_BITS (COORD_BITS)
    ) u_cell_x (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl_i (rd_ctl),
        .p_i   (ram_rdata[COORD_BITS-1:0]),
        .q_i   (qx_reg),
        .ctl_o (cell_ctl),
        .p_o   (cell_px),
        .sq_o  (sq_x),
        .busy  (busy_x)
    );

    nps_axis_cell #(
        .COORD_BITS (COORD_BITS)
    ) u_cell_y (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl_i (rd_ctl),
        .p_i   (ram_rdata[PW-1:COORD_BITS]),
        .q_i   (qy_reg),
        .ctl_o (cell_ctl_y),
        .p_o   (cell_py),
        .sq_o  (sq_y),
        .busy  (busy_y)
    );

    // sum of the two axis squares
    always_ff @(posedge clk)
    begin
        sum_reg    <= DW'(sq_x) + DW'(sq_y);
        sum_px_reg <= cell_px;
        sum_py_reg <= cell_py;
    end

    nps_best #(
        .COORD_BITS (COORD_BITS)
    ) u_best (
        .clk    (clk),
        .ctl_i  (sum_ctl_reg),
        .dist_i (sum_reg),
        .px_i   (sum_px_reg),
        .py_i   (sum_py_reg),
        .best_d (best_d),
        .best_x (best_x),
        .best_y (best_y)
    );

    // output register
    always_ff @(posedge clk)
    begin
        if (fin_load)
        begin
            if (empty_reg)
            begin
                out_x_reg <= nps_pkg::COORD_W'(qx_reg);
                out_y_reg <= nps_pkg::COORD_W'(qy_reg);
                out_d_reg <= '0;
            end
            else
            begin
                out_x_reg <= nps_pkg::COORD_W'(best_x);
                out_y_reg <= nps_pkg::COORD_W'(best_y);
                out_d_reg <= nps_pkg::DIST_W'(best_d);
            end
            out_empty_reg <= empty_reg;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign nearest_x   = out_x_reg;
    assign nearest_y   = out_y_reg;
    assign sq_distance = out_d_reg;
    assign set_empty   = out_empty_reg;
    assign overflowed  = out_ovf_reg;

    // checks
    `NPS_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(MAX_POINTS))
    `NPS_ASSERT_SAME(a_read_in_scan, clk, rst_n, rdv_reg, scan_or_drain)
    `NPS_ASSERT_NEXT(a_full_load_flags, clk, rst_n, is_load && store_full, ovf_reg)
    `NPS_ASSERT_SAME(a_empty_zero_dist, clk, rst_n, out_valid_reg && out_empty_reg, out_d_reg == '0)
    `NPS_ASSERT_SAME(a_cells_in_step, clk, rst_n, 1'b1, cell_ctl == cell_ctl_y)

endmodule
